// ----- design/ddays_pkg.sv -----
// Shared types, constants and calendar tables for the date difference block.
`default_nettype none

package ddays_pkg;

   // Field widths of the transactions.
   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DIST_W  = 25;

   // Divide-by-100 unit: year >> 2 is divided by 25 through a reciprocal multiply.
   localparam int QUART_W = YEAR_W - 2;
   localparam int QUOT_W  = 10;
   localparam int RECIP_W = 11;
   localparam int PROD_W  = 25;
   localparam int REM_W   = QUART_W + 1;
   localparam int RECIP_SHIFT = 15;

   localparam logic [RECIP_W-1:0] RECIP_25      = 11'd1310;
   localparam logic [REM_W-1:0]   DIVISOR_25    = 15'd25;
   localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

   // Calendar constants.
   localparam logic [MONTH_W-1:0] JANUARY         = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY        = 4'd2;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY       = 5'd1;
   localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS   = 5'd29;
   localparam logic [DAY_W-1:0]   COMMON_FEB_DAYS = 5'd28;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_Y,
      ST_FIX_Y,
      ST_DIV_P,
      ST_FIX_P,
      ST_YEAR,
      ST_MONTH,
      ST_DIFF,
      ST_DONE
   } ddays_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_go;
      logic div_prev;
      logic fix_leap;
      logic fix_q;
      logic year_go;
      logic month_go;
      logic diff_go;
      logic sel;
   } ddays_cmd_type;

   // Length of a month; the month must already be clamped to 1..12.
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         FEBRUARY:           len = leap ? LEAP_FEB_DAYS : COMMON_FEB_DAYS;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:            len = 5'd31;
      endcase
      return len;
   endfunction

   // Days in the months before the given one, in a common year.
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [8:0] off;
      case (m)
         4'd2:    off = 9'd31;
         4'd3:    off = 9'd59;
         4'd4:    off = 9'd90;
         4'd5:    off = 9'd120;
         4'd6:    off = 9'd151;
         4'd7:    off = 9'd181;
         4'd8:    off = 9'd212;
         4'd9:    off = 9'd243;
         4'd10:   off = 9'd273;
         4'd11:   off = 9'd304;
         4'd12:   off = 9'd334;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

// ----- design/ddays_req_if.sv -----
// Request channel interface carrying the two dates.
`default_nettype none

interface ddays_req_if
   import ddays_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  first_year;
   logic [MONTH_W-1:0] first_month;
   logic [DAY_W-1:0]   first_day;
   logic [YEAR_W-1:0]  second_year;
   logic [MONTH_W-1:0] second_month;
   logic [DAY_W-1:0]   second_day;

   modport source (
      output valid, first_year, first_month, first_day,
             second_year, second_month, second_day,
      input  ready
   );

   modport sink (
      input  valid, first_year, first_month, first_day,
             second_year, second_month, second_day,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/ddays_rsp_if.sv -----
// Response channel interface carrying the day distance.
`default_nettype none

interface ddays_rsp_if
   import ddays_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] day_distance;

   modport source (
      output valid, day_distance,
      input  ready
   );

   modport sink (
      input  valid, day_distance,
      output ready
   );
endinterface

`default_nettype wire

// ----- design/ddays_ctrl.sv -----
// Controller state machine that sequences the day ordinal computation.
`default_nettype none

module ddays_ctrl
   import ddays_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output ddays_cmd_type      cmd
);

   ddays_state_type state_ff, state_in;
   logic            sel_ff, sel_in;

   // State and date select registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // Next state: each date runs through the year and month steps in turn.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV_Y;
               sel_in   = 1'b0;
            end
         end
         ST_DIV_Y: state_in = ST_FIX_Y;
         ST_FIX_Y: state_in = ST_DIV_P;
         ST_DIV_P: state_in = ST_FIX_P;
         ST_FIX_P: state_in = ST_YEAR;
         ST_YEAR:  state_in = ST_MONTH;
         ST_MONTH: begin
            if (sel_ff) begin
               state_in = ST_DIFF;
            end else begin
               state_in = ST_DIV_Y;
               sel_in   = 1'b1;
            end
         end
         ST_DIFF:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake signals and datapath commands.
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.sel      = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV_Y: cmd.div_go = 1'b1;
         ST_FIX_Y: cmd.fix_leap = 1'b1;
         ST_DIV_P: begin
            cmd.div_go   = 1'b1;
            cmd.div_prev = 1'b1;
         end
         ST_FIX_P: cmd.fix_q = 1'b1;
         ST_YEAR:  cmd.year_go = 1'b1;
         ST_MONTH: cmd.month_go = 1'b1;
         ST_DIFF:  cmd.diff_go = 1'b1;
         ST_DONE:  rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/ddays_dp.sv -----
// Datapath: date registers, divide-by-100 unit, ordinal adders and distance.
`default_nettype none

module ddays_dp
   import ddays_pkg::*;
(
   input  wire logic               clock,
   input  wire ddays_cmd_type      cmd,
   input  wire logic [YEAR_W-1:0]  first_year,
   input  wire logic [MONTH_W-1:0] first_month,
   input  wire logic [DAY_W-1:0]   first_day,
   input  wire logic [YEAR_W-1:0]  second_year,
   input  wire logic [MONTH_W-1:0] second_month,
   input  wire logic [DAY_W-1:0]   second_day,
   output logic [DIST_W-1:0]       day_distance
);

   logic [YEAR_W-1:0]  y0_ff, y1_ff;
   logic [MONTH_W-1:0] m0_ff, m1_ff;
   logic [DAY_W-1:0]   d0_ff, d1_ff;
   logic [QUART_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QUOT_W-1:0]  q_ff;
   logic               leap_ff, leap_in;
   logic [DIST_W-1:0]  base_ff, base_in;
   logic [DIST_W-1:0]  ord0_ff, ord1_ff, ord_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;

   logic [YEAR_W-1:0]  cur_y, prev_y, opnd;
   logic [MONTH_W-1:0] cur_m, mc;
   logic [DAY_W-1:0]   cur_d, dc, last;
   logic [QUOT_W-1:0]  q_est, q_fix;
   logic [REM_W-1:0]   rem;
   logic               rem_zero;

   // Operands of the date being worked on.
   always_comb begin
      cur_y  = cmd.sel ? y1_ff : y0_ff;
      cur_m  = cmd.sel ? m1_ff : m0_ff;
      cur_d  = cmd.sel ? d1_ff : d0_ff;
      prev_y = cur_y - 16'd1;
   end

   // Divide step one: quarter of the operand times the reciprocal of 25.
   always_comb begin
      opnd    = cmd.div_prev ? prev_y : cur_y;
      x_in    = opnd[YEAR_W-1:2];
      prod_in = PROD_W'(x_in) * PROD_W'(RECIP_25);
   end

   // Divide step two: the estimate is low by at most one, so one compare fixes it.
   always_comb begin
      q_est    = prod_ff[RECIP_SHIFT +: QUOT_W];
      rem      = REM_W'(x_ff) - REM_W'(q_est) * DIVISOR_25;
      q_fix    = (rem >= DIVISOR_25) ? q_est + 10'd1 : q_est;
      rem_zero = (rem == '0) || (rem == DIVISOR_25);
      leap_in  = (cur_y[1:0] == 2'b00) && (!rem_zero || (q_fix[1:0] == 2'b00));
   end

   // Days before January 1 of the year.
   always_comb begin
      if (cur_y == '0) begin
         base_in = '0;
      end else begin
         base_in = DIST_W'(cur_y) * DIST_W'(DAYS_PER_YEAR)
                 + DIST_W'(prev_y[YEAR_W-1:2])
                 + DIST_W'(q_ff[QUOT_W-1:2])
                 + DIST_W'(1)
                 - DIST_W'(q_ff);
      end
   end

   // Month and day clamped into range, then added to the year base.
   always_comb begin
      if (cur_m < JANUARY) begin
         mc = JANUARY;
      end else if (cur_m > MONTHS_PER_YEAR) begin
         mc = MONTHS_PER_YEAR;
      end else begin
         mc = cur_m;
      end
      last = month_days(mc, leap_ff);
      if (cur_d < FIRST_DAY) begin
         dc = FIRST_DAY;
      end else if (cur_d > last) begin
         dc = last;
      end else begin
         dc = cur_d;
      end
      ord_in = base_ff + DIST_W'(month_offset(mc))
             + DIST_W'(leap_ff && (mc > FEBRUARY))
             + DIST_W'(dc) - DIST_W'(1);
   end

   // Absolute difference of the two ordinals.
   always_comb begin
      dist_in = (ord0_ff >= ord1_ff) ? ord0_ff - ord1_ff : ord1_ff - ord0_ff;
   end

   // Datapath registers, each written under its command.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         y0_ff <= first_year;
         m0_ff <= first_month;
         d0_ff <= first_day;
         y1_ff <= second_year;
         m1_ff <= second_month;
         d1_ff <= second_day;
      end
      if (cmd.div_go) begin
         x_ff    <= x_in;
         prod_ff <= prod_in;
      end
      if (cmd.fix_leap) begin
         leap_ff <= leap_in;
      end
      if (cmd.fix_q) begin
         q_ff <= q_fix;
      end
      if (cmd.year_go) begin
         base_ff <= base_in;
      end
      if (cmd.month_go) begin
         if (cmd.sel) begin
            ord1_ff <= ord_in;
         end else begin
            ord0_ff <= ord_in;
         end
      end
      if (cmd.diff_go) begin
         dist_ff <= dist_in;
      end
   end

   assign day_distance = dist_ff;

endmodule

`default_nettype wire

// ----- design/date_difference_in_days.sv -----
// Each date takes six steps through the shared divide-by-100 unit and the ordinal
// adders, then one step forms the distance and the response is presented.
// A new request is taken only after the response transaction completes.
// Reset is synchronous and active high; it returns the controller to idle.
`default_nettype none

module date_difference_in_days
   import ddays_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ddays_req_if.sink   req_chan,
   ddays_rsp_if.source rsp_chan
);

   ddays_cmd_type cmd;

   // Sequencing of the computation and the handshakes.
   ddays_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Arithmetic on the two dates.
   ddays_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .first_year   (req_chan.first_year),
      .first_month  (req_chan.first_month),
      .first_day    (req_chan.first_day),
      .second_year  (req_chan.second_year),
      .second_month (req_chan.second_month),
      .second_day   (req_chan.second_day),
      .day_distance (rsp_chan.day_distance)
   );

endmodule

`default_nettype wire

// ----- test/date_difference_in_days_tb.sv -----
// Self-checking testbench for the date difference block: directed and random date pairs.
`timescale 1ns / 1ps

module date_difference_in_days_tb;
   import ddays_pkg::*;

   // One request transaction: two calendar dates.
   typedef struct {
      logic [YEAR_W-1:0]  first_year;
      logic [MONTH_W-1:0] first_month;
      logic [DAY_W-1:0]   first_day;
      logic [YEAR_W-1:0]  second_year;
      logic [MONTH_W-1:0] second_month;
      logic [DAY_W-1:0]   second_day;
   } date_pair_type;

   logic clock;
   logic reset;

   ddays_req_if req_bus ();
   ddays_rsp_if rsp_bus ();

   date_difference_in_days u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   date_pair_type     pending_pairs[$];
   logic [DIST_W-1:0] expected_distances[$];
   date_pair_type     pair_on_wire;
   int                n_accepted;
   int                n_total;
   int                error_count;
   int                send_idle_left;
   int                recv_stall_left;
   logic              calm;

   // Gregorian leap rule.
   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // Month length for a month already in 1..12.
   function automatic int unsigned month_length(input int unsigned m, input bit leap);
      int unsigned len;
      case (m)
         2:             len = leap ? 29 : 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   // Days from the first day of year zero, with month and day clamped into range.
   function automatic int unsigned ordinal_of(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
      int unsigned n;
      int unsigned prev;
      bit          leap;
      leap = is_leap(y);
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > month_length(m, leap)) d = month_length(m, leap);
      n = 0;
      if (y > 0) begin
         prev = y - 1;
         n = 365 * y + prev / 4 - prev / 100 + prev / 400 + 1;
      end
      for (int unsigned i = 1; i < m; i++) begin
         n += month_length(i, leap);
      end
      return n + d - 1;
   endfunction

   // Absolute day distance between the two dates of a transaction.
   function automatic logic [DIST_W-1:0] distance_of(input date_pair_type p);
      int unsigned a;
      int unsigned b;
      a = ordinal_of(p.first_year, p.first_month, p.first_day);
      b = ordinal_of(p.second_year, p.second_month, p.second_day);
      return (a >= b) ? DIST_W'(a - b) : DIST_W'(b - a);
   endfunction

   // Idle lengths: mostly short, now and then long.
   function automatic int pick_idle();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(20, 60);
      end
      return $urandom_range(0, 3);
   endfunction

   function automatic date_pair_type make_pair(input int y1, input int m1, input int d1,
                                               input int y2, input int m2, input int d2);
      date_pair_type p;
      p.first_year   = YEAR_W'(y1);
      p.first_month  = MONTH_W'(m1);
      p.first_day    = DAY_W'(d1);
      p.second_year  = YEAR_W'(y2);
      p.second_month = MONTH_W'(m2);
      p.second_day   = DAY_W'(d2);
      return p;
   endfunction

   // A date that is valid in its own year.
   task automatic random_date(output int y, output int m, output int d, input int year);
      y = year;
      m = $urandom_range(1, 12);
      d = $urandom_range(1, month_length(m, is_leap(year)));
   endtask

   // Stretch with no idling on either side, part way through the random items.
   assign calm = (n_accepted >= 70) && (n_accepted < 95);

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Request driver: presents queued date pairs and records each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         send_idle_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_distances.push_back(distance_of(pair_on_wire));
            n_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_idle_left > 0) begin
               send_idle_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               pair_on_wire = pending_pairs.pop_front();
               req_bus.first_year   <= pair_on_wire.first_year;
               req_bus.first_month  <= pair_on_wire.first_month;
               req_bus.first_day    <= pair_on_wire.first_day;
               req_bus.second_year  <= pair_on_wire.second_year;
               req_bus.second_month <= pair_on_wire.second_month;
               req_bus.second_day   <= pair_on_wire.second_day;
               req_bus.valid        <= 1'b1;
               send_idle_left = calm ? 0 : pick_idle();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted transaction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         recv_stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: unexpected response, day_distance %0d", $time,
                        rsp_bus.day_distance);
               error_count++;
            end else begin
               logic [DIST_W-1:0] want;
               want = expected_distances.pop_front();
               if (rsp_bus.day_distance !== want) begin
                  $display("%0t: day_distance mismatch, expected %0d, actual %0d", $time,
                           want, rsp_bus.day_distance);
                  error_count++;
               end
            end
         end
         if (recv_stall_left > 0) begin
            recv_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_stall_left = pick_idle();
            rsp_bus.ready   <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int y1, m1, d1, y2, m2, d2;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.first_year   = '0;
      req_bus.first_month  = '0;
      req_bus.first_day    = '0;
      req_bus.second_year  = '0;
      req_bus.second_month = '0;
      req_bus.second_day   = '0;
      rsp_bus.ready        = 1'b0;
      n_accepted           = 0;
      error_count          = 0;

      // Directed cases: field extremes, clamping and leap-year boundaries.
      pending_pairs.push_back(make_pair(2024, 2, 29, 2024, 2, 29));
      pending_pairs.push_back(make_pair(0, 1, 1, 65535, 12, 31));
      pending_pairs.push_back(make_pair(65535, 12, 31, 0, 1, 1));
      pending_pairs.push_back(make_pair(2000, 0, 15, 2000, 1, 15));
      pending_pairs.push_back(make_pair(1999, 15, 31, 1999, 13, 1));
      pending_pairs.push_back(make_pair(2023, 5, 0, 2023, 5, 1));
      pending_pairs.push_back(make_pair(2023, 4, 31, 2023, 5, 1));
      pending_pairs.push_back(make_pair(2023, 2, 30, 2023, 3, 1));
      pending_pairs.push_back(make_pair(1900, 2, 29, 1900, 3, 1));
      pending_pairs.push_back(make_pair(2000, 2, 31, 2000, 3, 1));
      pending_pairs.push_back(make_pair(2100, 2, 28, 2100, 3, 1));
      pending_pairs.push_back(make_pair(0, 2, 29, 0, 3, 1));
      pending_pairs.push_back(make_pair(400, 12, 31, 401, 1, 1));
      pending_pairs.push_back(make_pair(65535, 15, 31, 65535, 0, 0));
      pending_pairs.push_back(make_pair(1, 1, 1, 0, 12, 31));
      pending_pairs.push_back(make_pair(2024, 1, 1, 2025, 1, 1));
      pending_pairs.push_back(make_pair(1970, 1, 1, 2038, 1, 19));
      pending_pairs.push_back(make_pair(65535, 2, 29, 65534, 12, 31));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 15, 31));
      pending_pairs.push_back(make_pair(32767, 8, 16, 32768, 7, 15));

      // Random cases: mostly valid dates, some close together, some raw field bits.
      for (int i = 0; i < 80; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               pending_pairs.push_back(make_pair($urandom_range(0, 65535),
                  $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 65535),
                  $urandom_range(0, 15), $urandom_range(0, 31)));
            end
            2, 3, 4: begin
               random_date(y1, m1, d1, $urandom_range(0, 65535));
               y2 = y1 + $urandom_range(0, 4) - 2;
               if (y2 < 0) y2 = 0;
               if (y2 > 65535) y2 = 65535;
               random_date(y2, m2, d2, y2);
               pending_pairs.push_back(make_pair(y1, m1, d1, y2, m2, d2));
            end
            default: begin
               random_date(y1, m1, d1, $urandom_range(0, 65535));
               random_date(y2, m2, d2, $urandom_range(0, 65535));
               pending_pairs.push_back(make_pair(y1, m1, d1, y2, m2, d2));
            end
         endcase
      end
      n_total = pending_pairs.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Wait for every transaction to be accepted and answered, then drain.
      while (n_accepted < n_total || expected_distances.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
